/* rtl/ascd_pkg.sv */
// Shared types, constants and command text for the ASCII score command decoder.
`default_nettype none

package ascd_pkg;

  localparam logic [9:0] SCORE_MAX = 10'd999;
  localparam logic [1:0] SLOT_MAX  = 2'd3;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Bit positions of the commands in the prefix match mask
  localparam int unsigned CMD_COUNT = 5;
  localparam int unsigned BIT_SEL   = 0;
  localparam int unsigned BIT_ANG   = 1;
  localparam int unsigned BIT_SCR   = 2;
  localparam int unsigned BIT_GO    = 3;
  localparam int unsigned BIT_RB    = 4;

  localparam logic [2:0] SEL_ARG_START = 3'd7;
  localparam logic [2:0] SCR_ARG_START = 3'd5;

  // Command text, first character in the top byte, short commands zero padded
  localparam logic [55:0] TEXT_SEL = "CC:SEL,";
  localparam logic [55:0] TEXT_ANG = {"CC:A,", 16'h0000};
  localparam logic [55:0] TEXT_SCR = {"CC:S,", 16'h0000};
  localparam logic [55:0] TEXT_GO  = "CC:GO,1";
  localparam logic [55:0] TEXT_RB  = {"CC:RB", 16'h0000};

  // Command decoded at the end of a line
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_SEL  = 3'd1,
    OP_SCR  = 3'd2,
    OP_GO   = 3'd3,
    OP_RB   = 3'd4
  } op_t;

  // Request from the line parser to the score unit
  typedef struct packed {
    op_t        op;
    logic       negative;
    logic [9:0] accum;
  } line_cmd_t;

  // Argument parse phase
  typedef enum logic [3:0] {
    PH_LEAD = 4'b0001,
    PH_SIGN = 4'b0010,
    PH_DIGS = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  // Length of command k in characters
  function automatic logic [2:0] cmd_len(input int unsigned k);
    logic [2:0] len;
    case (k)
      BIT_SEL: len = 3'd7;
      BIT_GO:  len = 3'd7;
      default: len = 3'd5;
    endcase
    return len;
  endfunction

  // Character p of command k
  function automatic logic [7:0] cmd_char(input int unsigned k, input logic [2:0] p);
    logic [55:0] t;
    case (k)
      BIT_SEL: t = TEXT_SEL;
      BIT_ANG: t = TEXT_ANG;
      BIT_SCR: t = TEXT_SCR;
      BIT_GO:  t = TEXT_GO;
      default: t = TEXT_RB;
    endcase
    return t[8 * (6 - int'(p)) +: 8];
  endfunction

endpackage

`default_nettype wire

/* rtl/ascd_line_parser.sv */
// Line assembly, prefix matching and decimal argument parsing.
`default_nettype none

module ascd_line_parser #(
  parameter int unsigned LINE_BUFFER_BYTES = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire logic [7:0]          rx_byte,
  output ascd_pkg::line_cmd_t      cmd
);

  localparam int unsigned CNT_W = $clog2(LINE_BUFFER_BYTES);
  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(LINE_BUFFER_BYTES - 1);

  logic [CNT_W-1:0]     line_count, line_count_next;
  logic [4:0]           prefix_match, prefix_match_next;
  ascd_pkg::phase_t     arg_phase, arg_phase_next;
  logic                 arg_negative, arg_negative_next;
  logic [9:0]           arg_accum, arg_accum_next;

  logic        is_eol;
  logic        is_digit;
  logic        is_space;
  logic [13:0] digit_sum;
  logic [9:0]  digit_accum;
  logic        feed;

  assign is_eol   = (rx_byte == ascd_pkg::CHAR_CR) || (rx_byte == ascd_pkg::CHAR_LF);
  assign is_digit = (rx_byte >= "0") && (rx_byte <= "9");
  assign is_space = (rx_byte == 8'h20) || (rx_byte == 8'h09) ||
                    (rx_byte == 8'h0B) || (rx_byte == 8'h0C);

  // Times ten plus digit, saturated to the score limit
  assign digit_sum   = 14'(arg_accum) * 14'd10 + {10'd0, rx_byte[3:0]};
  assign digit_accum = (digit_sum > 14'(ascd_pkg::SCORE_MAX)) ? ascd_pkg::SCORE_MAX
                                                              : digit_sum[9:0];

  // Next line state and the command ending this line
  always_comb begin
    line_count_next   = line_count;
    prefix_match_next = prefix_match;
    arg_phase_next    = arg_phase;
    arg_negative_next = arg_negative;
    arg_accum_next    = arg_accum;
    feed              = 1'b0;
    cmd.op            = ascd_pkg::OP_NONE;
    cmd.negative      = arg_negative;
    cmd.accum         = arg_accum;

    if (is_eol) begin
      if (line_count != '0) begin
        if (prefix_match[ascd_pkg::BIT_SEL] &&
            line_count >= CNT_W'(ascd_pkg::cmd_len(ascd_pkg::BIT_SEL))) begin
          cmd.op = ascd_pkg::OP_SEL;
        end else if (prefix_match[ascd_pkg::BIT_ANG] &&
                     line_count >= CNT_W'(ascd_pkg::cmd_len(ascd_pkg::BIT_ANG))) begin
          cmd.op = ascd_pkg::OP_NONE;
        end else if (prefix_match[ascd_pkg::BIT_SCR] &&
                     line_count >= CNT_W'(ascd_pkg::cmd_len(ascd_pkg::BIT_SCR))) begin
          cmd.op = ascd_pkg::OP_SCR;
        end else if (prefix_match[ascd_pkg::BIT_GO] &&
                     line_count >= CNT_W'(ascd_pkg::cmd_len(ascd_pkg::BIT_GO))) begin
          cmd.op = ascd_pkg::OP_GO;
        end else if (prefix_match[ascd_pkg::BIT_RB] &&
                     line_count >= CNT_W'(ascd_pkg::cmd_len(ascd_pkg::BIT_RB))) begin
          cmd.op = ascd_pkg::OP_RB;
        end
      end
      line_count_next   = '0;
      prefix_match_next = '1;
      arg_phase_next    = ascd_pkg::PH_LEAD;
      arg_negative_next = 1'b0;
      arg_accum_next    = '0;
    end else if (line_count < COUNT_LIMIT) begin
      // Drop commands whose text differs at this position
      for (int unsigned k = 0; k < ascd_pkg::CMD_COUNT; k++) begin
        if (line_count < CNT_W'(ascd_pkg::cmd_len(k)) &&
            rx_byte != ascd_pkg::cmd_char(k, line_count[2:0])) begin
          prefix_match_next[k] = 1'b0;
        end
      end
      if (prefix_match_next[ascd_pkg::BIT_SEL]) begin
        feed = line_count >= CNT_W'(ascd_pkg::SEL_ARG_START);
      end else if (prefix_match_next[ascd_pkg::BIT_SCR]) begin
        feed = line_count >= CNT_W'(ascd_pkg::SCR_ARG_START);
      end
      // Argument: skip spaces, take a sign, then digits
      if (feed) begin
        unique case (arg_phase)
          ascd_pkg::PH_LEAD: begin
            if (is_space) begin
              arg_phase_next = ascd_pkg::PH_LEAD;
            end else if (rx_byte == "+") begin
              arg_phase_next = ascd_pkg::PH_SIGN;
            end else if (rx_byte == "-") begin
              arg_negative_next = 1'b1;
              arg_phase_next    = ascd_pkg::PH_SIGN;
            end else if (is_digit) begin
              arg_accum_next = digit_accum;
              arg_phase_next = ascd_pkg::PH_DIGS;
            end else begin
              arg_phase_next = ascd_pkg::PH_DONE;
            end
          end
          ascd_pkg::PH_SIGN, ascd_pkg::PH_DIGS: begin
            if (is_digit) begin
              arg_accum_next = digit_accum;
              arg_phase_next = ascd_pkg::PH_DIGS;
            end else begin
              arg_phase_next = ascd_pkg::PH_DONE;
            end
          end
          default: begin
            arg_phase_next = ascd_pkg::PH_DONE;
          end
        endcase
      end
      line_count_next = line_count + 1'b1;
    end else begin
      // Overlong line: drop it and this character
      line_count_next   = '0;
      prefix_match_next = '1;
      arg_phase_next    = ascd_pkg::PH_LEAD;
      arg_negative_next = 1'b0;
      arg_accum_next    = '0;
    end
  end

  // Advance line state on each processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= '0;
      prefix_match <= '1;
      arg_phase    <= ascd_pkg::PH_LEAD;
      arg_negative <= 1'b0;
      arg_accum    <= '0;
    end else if (fire) begin
      line_count   <= line_count_next;
      prefix_match <= prefix_match_next;
      arg_phase    <= arg_phase_next;
      arg_negative <= arg_negative_next;
      arg_accum    <= arg_accum_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/ascd_score_exec.sv */
// Score, slot and best store state, command execution and the result register.
`default_nettype none

module ascd_score_exec (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  ascd_pkg::line_cmd_t      cmd,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [9:0]          cfg_data,
  output logic                     ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_kind,
  output logic [9:0]               out_value,
  output logic [1:0]               out_slot,
  output logic                     out_store_write
);

  logic [1:0] selected_slot;
  logic [9:0] live_score;
  logic [9:0] current_best;
  logic [9:0] best_store [4];

  logic [1:0] arg_slot;
  logic [9:0] arg_score;
  logic [9:0] cfg_best;
  logic       improved;

  // Take a register write only in a cycle that processes no request
  assign cfg_ready = !fire;
  assign ready     = !out_valid || out_ready;

  // Clamp the argument for each use
  assign arg_slot  = cmd.negative ? 2'd0 :
                     (cmd.accum > 10'(ascd_pkg::SLOT_MAX)) ? ascd_pkg::SLOT_MAX : cmd.accum[1:0];
  assign arg_score = cmd.negative ? 10'd0 :
                     (cmd.accum > ascd_pkg::SCORE_MAX) ? ascd_pkg::SCORE_MAX : cmd.accum;
  assign cfg_best  = (cfg_data > ascd_pkg::SCORE_MAX) ? ascd_pkg::SCORE_MAX : cfg_data;
  assign improved  = live_score > current_best;

  // Execute the command and load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      selected_slot <= 2'd0;
      live_score    <= 10'd0;
      current_best  <= 10'd0;
      for (int i = 0; i < 4; i++) begin
        best_store[i] <= 10'd0;
      end
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        current_best <= cfg_best;
      end
      if (fire && cmd.op != ascd_pkg::OP_NONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        unique case (cmd.op)
          ascd_pkg::OP_SEL: begin
            selected_slot   <= arg_slot;
            current_best    <= best_store[arg_slot];
            out_kind        <= 1'b0;
            out_value       <= best_store[arg_slot];
            out_slot        <= arg_slot;
            out_store_write <= 1'b0;
          end
          ascd_pkg::OP_SCR: begin
            live_score      <= arg_score;
            out_kind        <= 1'b0;
            out_value       <= arg_score;
            out_slot        <= selected_slot;
            out_store_write <= 1'b0;
          end
          ascd_pkg::OP_GO: begin
            out_kind <= 1'b1;
            out_slot <= selected_slot;
            if (improved) begin
              current_best              <= live_score;
              best_store[selected_slot] <= live_score;
              out_value                 <= live_score;
              out_store_write           <= 1'b1;
            end else begin
              out_value       <= current_best;
              out_store_write <= 1'b0;
            end
          end
          ascd_pkg::OP_RB: begin
            out_kind        <= 1'b1;
            out_value       <= current_best;
            out_slot        <= selected_slot;
            out_store_write <= 1'b0;
          end
          default: begin
            out_kind        <= 1'b0;
            out_slot        <= selected_slot;
            out_store_write <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/ascii_score_command_decoder.sv */
// Top level of the ASCII score command decoder: input register, parser and score unit.
`default_nettype none

// Channel   Direction  Payload
// s_axis    in         s_tdata[7:0] = rx_byte
// m_axis    out        m_tuser = kind; m_tdata = value, slot, store_write
// cfg       in         cfg_data[9:0] = initial_best
//
// One character is accepted per cycle while the result register is not stalled; a command
// result for a CR or LF is offered on m_tvalid behind the input register and the result register.
// Reset (rst, synchronous) clears the line, the slot, the scores and all four stored bests.
// A stalled result register holds its request and back-pressures the input register,
// which takes one more character if it is empty before s_tready drops.

module ascii_score_command_decoder #(
  parameter int unsigned LINE_BUFFER_BYTES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [9:0] value, [11:10] slot, [12] store_write
  output logic             m_tuser,   // [0] kind
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [9:0]  cfg_data
);

  logic                in_valid;
  logic [7:0]          in_byte;
  logic                exec_ready;
  logic                fire;
  ascd_pkg::line_cmd_t cmd;
  logic [9:0]          out_value;
  logic [1:0]          out_slot;
  logic                out_store_write;

  assign fire     = in_valid && exec_ready;
  assign s_tready = !in_valid || fire;

  // Hold the incoming character until the parser takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  ascd_line_parser #(
    .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (in_byte),
    .cmd     (cmd)
  );

  ascd_score_exec u_exec (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .cmd             (cmd),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .ready           (exec_ready),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_kind        (m_tuser),
    .out_value       (out_value),
    .out_slot        (out_slot),
    .out_store_write (out_store_write)
  );

  assign m_tdata = {3'b000, out_store_write, out_slot, out_value};

endmodule

`default_nettype wire

/* tb/ascii_score_command_decoder_checker.sv */
// Checker for the ASCII score command decoder: predicts every result and compares it.
`timescale 1ns / 1ps

module ascii_score_command_decoder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] rx_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,    // [9:0] value, [11:10] slot, [12] store_write
  input  logic        m_tuser,    // [0] kind
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [9:0]  cfg_data,
  output int          failures,
  output int          pending,
  output int          checked
);

  // A line keeps at most this many characters; one more drops it
  localparam int LINE_MAX_CHARS = 31;

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_VTAB     = 8'h0B;
  localparam logic [7:0] CH_FORMFEED = 8'h0C;

  typedef struct packed {
    logic       kind;
    logic [9:0] value;
    logic [1:0] slot;
    logic       store_write;
  } score_result_t;

  // Predicted decoder state
  logic [4:0]         line_len;
  logic [4:0]         still_matching;
  ascd_pkg::phase_t   arg_state;
  logic               arg_minus;
  logic [9:0]         arg_sum;
  logic [1:0]         cur_slot;
  logic [9:0]         live_pts;
  logic [9:0]         best_pts;
  logic [9:0]         slot_best [4];

  score_result_t results_due [$];

  function automatic string cmd_text(input int unsigned k);
    case (k)
      ascd_pkg::BIT_SEL: return "CC:SEL,";
      ascd_pkg::BIT_ANG: return "CC:A,";
      ascd_pkg::BIT_SCR: return "CC:S,";
      ascd_pkg::BIT_GO:  return "CC:GO,1";
      default:           return "CC:RB";
    endcase
  endfunction

  function automatic bit is_matched(input int unsigned k);
    string t;
    t = cmd_text(k);
    return still_matching[k] && (int'(line_len) >= t.len());
  endfunction

  // Negative arguments read as zero, large ones as the limit
  function automatic logic [9:0] clamp_arg(input logic [9:0] limit);
    if (arg_minus) return '0;
    return (arg_sum > limit) ? limit : arg_sum;
  endfunction

  task automatic clear_line();
    line_len       = '0;
    still_matching = '1;
    arg_state      = ascd_pkg::PH_LEAD;
    arg_minus      = 1'b0;
    arg_sum        = '0;
  endtask

  task automatic add_digit(input logic [7:0] c);
    int sum;
    sum = int'(arg_sum) * 10 + int'(c - "0");
    arg_sum   = (sum > int'(ascd_pkg::SCORE_MAX)) ? ascd_pkg::SCORE_MAX : sum[9:0];
    arg_state = ascd_pkg::PH_DIGS;
  endtask

  task automatic feed_argument(input logic [7:0] c);
    bit digit;
    digit = (c >= "0") && (c <= "9");
    case (arg_state)
      ascd_pkg::PH_LEAD: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_VTAB || c == CH_FORMFEED) begin
          // skip leading blanks
        end else if (c == "+") begin
          arg_state = ascd_pkg::PH_SIGN;
        end else if (c == "-") begin
          arg_minus = 1'b1;
          arg_state = ascd_pkg::PH_SIGN;
        end else if (digit) begin
          add_digit(c);
        end else begin
          arg_state = ascd_pkg::PH_DONE;
        end
      end
      ascd_pkg::PH_SIGN, ascd_pkg::PH_DIGS: begin
        if (digit) add_digit(c);
        else arg_state = ascd_pkg::PH_DONE;
      end
      default: ;
    endcase
  endtask

  // Narrow the candidate commands, then parse the argument past the prefix
  task automatic accept_char(input logic [7:0] c);
    int    pos;
    int    arg_from;
    string t;
    pos = int'(line_len);
    for (int k = 0; k < ascd_pkg::CMD_COUNT; k++) begin
      t = cmd_text(k);
      if (pos < t.len() && c != t[pos]) still_matching[k] = 1'b0;
    end
    if (still_matching[ascd_pkg::BIT_SEL]) arg_from = 7;
    else if (still_matching[ascd_pkg::BIT_SCR]) arg_from = 5;
    else arg_from = 0;
    if (arg_from != 0 && pos >= arg_from) feed_argument(c);
  endtask

  task automatic end_of_line(output bit has, output score_result_t r);
    has = 1'b1;
    r   = '0;
    if (is_matched(ascd_pkg::BIT_SEL)) begin
      cur_slot = 2'(clamp_arg({8'd0, ascd_pkg::SLOT_MAX}));
      best_pts = slot_best[cur_slot];
      r.value  = best_pts;
    end else if (is_matched(ascd_pkg::BIT_ANG)) begin
      has = 1'b0;
    end else if (is_matched(ascd_pkg::BIT_SCR)) begin
      live_pts = clamp_arg(ascd_pkg::SCORE_MAX);
      r.value  = live_pts;
    end else if (is_matched(ascd_pkg::BIT_GO)) begin
      if (live_pts > best_pts) begin
        best_pts            = live_pts;
        slot_best[cur_slot] = best_pts;
        r.store_write       = 1'b1;
      end
      r.kind  = 1'b1;
      r.value = best_pts;
    end else if (is_matched(ascd_pkg::BIT_RB)) begin
      r.kind  = 1'b1;
      r.value = best_pts;
    end else begin
      has = 1'b0;
    end
    r.slot = cur_slot;
  endtask

  task automatic take_byte(input logic [7:0] c);
    bit            has;
    score_result_t r;
    if (c == ascd_pkg::CHAR_CR || c == ascd_pkg::CHAR_LF) begin
      if (line_len != 0) begin
        end_of_line(has, r);
        if (has) results_due.push_back(r);
      end
      clear_line();
    end else if (int'(line_len) < LINE_MAX_CHARS) begin
      accept_char(c);
      line_len = line_len + 1'b1;
    end else begin
      clear_line();
    end
  endtask

  task automatic report(input string what);
    $display("ERROR at %0t: %s", $time, what);
    failures++;
  endtask

  task automatic compare_field(input string field, input int want, input int seen);
    if (want != seen) report($sformatf("%s expected %0d, got %0d", field, want, seen));
  endtask

  always @(posedge clk) begin : watch
    score_result_t want;
    if (rst) begin
      clear_line();
      cur_slot  = '0;
      live_pts  = '0;
      best_pts  = '0;
      for (int i = 0; i < 4; i++) slot_best[i] = '0;
      results_due.delete();
      failures  = 0;
      checked   = 0;
    end else begin
      // Compare the result leaving the block with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          report($sformatf("unexpected result, value %0d", m_tdata[9:0]));
        end else begin
          want = results_due.pop_front();
          compare_field("kind", want.kind, m_tuser);
          compare_field("value", want.value, m_tdata[9:0]);
          compare_field("slot", want.slot, m_tdata[11:10]);
          compare_field("store_write", want.store_write, m_tdata[12]);
          checked++;
        end
      end
      // Register write reloads the current best
      if (cfg_valid && cfg_ready) begin
        best_pts = (cfg_data > ascd_pkg::SCORE_MAX) ? ascd_pkg::SCORE_MAX : cfg_data;
      end
      // Advance the prediction by one received character
      if (s_tvalid && s_tready) take_byte(s_tdata);
    end
    pending <= results_due.size();
  end

endmodule

/* tb/ascii_score_command_decoder_test.sv */
// Stimulus and verdict for the ASCII score command decoder regression.
`timescale 1ns / 1ps

module ascii_score_command_decoder_test;

  localparam int RANDOM_CHARS = 1080;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 8;
  localparam int IDLE_LIMIT   = 3000;

  typedef enum int {
    LINE_SEL,
    LINE_SCORE,
    LINE_GO,
    LINE_BEST,
    LINE_ANGLE
  } line_kind_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;    // [9:0] value, [11:10] slot, [12] store_write
  logic        m_tuser;    // [0] kind
  logic        cfg_valid;
  logic        cfg_ready;
  logic [9:0]  cfg_data;

  int failures;
  int pending;
  int checked;

  int  chars_sent;
  int  cfg_writes;
  int  idle_cycles;
  bit  tx_steady;
  bit  rx_steady;
  bit  hold_off_req;
  bit  hold_active;

  logic [7:0] line_buf [$];

  ascii_score_command_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ascii_score_command_decoder_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // End the run when no request moves for too long
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR at %0t: no request accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("ascii_score_command_decoder regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, steady stretches, one long hold-off on request
  initial begin : result_side
    int run;
    int gap;
    m_tready    = 1'b0;
    rx_steady   = 1'b0;
    hold_active = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_active  = 1'b1;
        m_tready     = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active  = 1'b0;
      end else begin
        if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
        gap = rx_steady ? 0 : pick_gap();
        if (gap > 0) begin
          m_tready = 1'b0;
          repeat (gap) @(negedge clk);
        end
        m_tready = 1'b1;
        run = $urandom_range(1, 12);
        repeat (run) @(negedge clk);
      end
    end
  end

  // Offer one character and hold it until accepted
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = c;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic put_char(input logic [7:0] c);
    line_buf.push_back(c);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic flush_line();
    for (int i = 0; i < line_buf.size(); i++) send_char(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic say(input string s, input logic [7:0] ending);
    put_text(s);
    put_char(ending);
    flush_line();
  endtask

  task automatic wait_results_done();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write the start-up best once the block has gone quiet
  task automatic write_best(input logic [9:0] v);
    wait_results_done();
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [7:0] pick_ending();
    return ($urandom_range(0, 1) != 0) ? ascd_pkg::CHAR_CR : ascd_pkg::CHAR_LF;
  endfunction

  // Blanks, optional sign, some digits
  task automatic put_argument(input bit slot_arg);
    int n;
    n = $urandom_range(0, 2);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: put_char(8'h20);
        1: put_char(8'h09);
        2: put_char(8'h0B);
        default: put_char(8'h0C);
      endcase
    end
    case ($urandom_range(0, 5))
      0: put_char("+");
      1: put_char("-");
      default: ;
    endcase
    if (slot_arg && $urandom_range(0, 9) < 7) n = 1;
    else if ($urandom_range(0, 9) == 0) n = $urandom_range(5, 7);
    else n = $urandom_range(0, 4);
    repeat (n) put_char(8'(8'h30 + $urandom_range(0, 9)));
  endtask

  task automatic put_junk(input int n);
    repeat (n) put_char(8'($urandom_range(0, 255)));
  endtask

  task automatic random_line();
    int         r;
    int         n;
    string      t;
    line_kind_t which;
    if ($urandom_range(0, 7) == 0) tx_steady = !tx_steady;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      // well-formed command with random content
      case ($urandom_range(0, 9))
        0, 1:    which = LINE_SEL;
        2, 3, 4: which = LINE_SCORE;
        5, 6:    which = LINE_GO;
        7, 8:    which = LINE_BEST;
        default: which = LINE_ANGLE;
      endcase
      case (which)
        LINE_SEL:   begin put_text("CC:SEL,"); put_argument(1'b1); end
        LINE_SCORE: begin put_text("CC:S,"); put_argument(1'b0); end
        LINE_GO:    put_text("CC:GO,1");
        LINE_BEST:  put_text("CC:RB");
        default:    begin put_text("CC:A,"); put_argument(1'b0); end
      endcase
      if ($urandom_range(0, 9) == 0) put_junk($urandom_range(1, 6));
    end else if (r < 90) begin
      // raw noise, sometimes past the line limit
      put_junk($urandom_range(1, 40));
    end else begin
      // command cut short or with one character spoiled
      case ($urandom_range(0, 3))
        0: t = "CC:SEL,2";
        1: t = "CC:S,123";
        2: t = "CC:GO,1";
        default: t = "CC:RB";
      endcase
      if ($urandom_range(0, 1) != 0) begin
        n = $urandom_range(1, t.len() - 1);
        t = t.substr(0, n - 1);
        put_text(t);
      end else begin
        n = $urandom_range(0, t.len() - 1);
        for (int i = 0; i < t.len(); i++) begin
          if (i == n) put_char(8'($urandom_range(0, 255)));
          else put_char(t[i]);
        end
      end
    end
    put_char(pick_ending());
    if ($urandom_range(0, 9) == 0) put_char(pick_ending());
    flush_line();
  endtask

  function automatic logic [9:0] pick_best();
    case ($urandom_range(0, 5))
      0: return 10'd0;
      1: return ascd_pkg::SCORE_MAX;
      2: return 10'd1000;
      3: return 10'h3FF;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin : stimulus
    int  first_random;
    int  next_cfg_at;
    bit  pressure_done;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    chars_sent   = 0;
    cfg_writes   = 0;
    tx_steady    = 1'b0;
    hold_off_req = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Register above range saturates
    write_best(10'h3FF);
    say("CC:RB", ascd_pkg::CHAR_CR);
    write_best(10'd0);

    // Empty lines
    say("", ascd_pkg::CHAR_CR);
    say("", ascd_pkg::CHAR_LF);
    // Score argument forms and saturation
    say("CC:S,999", ascd_pkg::CHAR_LF);
    say("CC:S,1000", ascd_pkg::CHAR_CR);
    say("CC:S,-5", ascd_pkg::CHAR_LF);
    say("CC:S,  +42", ascd_pkg::CHAR_CR);
    put_text("CC:S,");
    put_char(8'h09);
    put_char(8'h0B);
    put_char(8'h0C);
    put_text("7x9");
    put_char(ascd_pkg::CHAR_LF);
    flush_line();
    say("CC:S,", ascd_pkg::CHAR_CR);
    put_text("CC:S,5");
    put_char(8'hFF);
    put_char(8'h00);
    put_char(ascd_pkg::CHAR_CR);
    flush_line();
    // Store an improved best, then one that does not improve
    say("CC:S,700", ascd_pkg::CHAR_CR);
    say("CC:GO,1", ascd_pkg::CHAR_LF);
    say("CC:GO,1", ascd_pkg::CHAR_CR);
    // Slot selection with saturation both ways
    say("CC:SEL,9", ascd_pkg::CHAR_CR);
    say("CC:SEL,-1", ascd_pkg::CHAR_LF);
    say("CC:SEL,2", ascd_pkg::CHAR_LF);
    // Ignored, short and prefix-only lines
    say("CC:A,123", ascd_pkg::CHAR_CR);
    say("CC:R", ascd_pkg::CHAR_CR);
    say("CC:GO,", ascd_pkg::CHAR_LF);
    say("CC:RBX", ascd_pkg::CHAR_LF);
    // Longest line kept, then one character too many
    say({"CC:RB", {26{"x"}}}, ascd_pkg::CHAR_CR);
    say({"CC:RB", {27{"x"}}}, ascd_pkg::CHAR_CR);

    // Random lines, with register changes and one long output stall
    first_random  = chars_sent;
    next_cfg_at   = chars_sent + $urandom_range(150, 350);
    pressure_done = 1'b0;
    while (chars_sent - first_random < RANDOM_CHARS) begin
      random_line();
      if (chars_sent >= next_cfg_at) begin
        write_best(pick_best());
        next_cfg_at = chars_sent + $urandom_range(150, 350);
      end
      if (!pressure_done && chars_sent - first_random >= RANDOM_CHARS / 2) begin
        hold_off_req = 1'b1;
        s_tvalid     = 1'b0;
        while (!hold_active) @(negedge clk);
        repeat (6) begin
          say("CC:RB", ascd_pkg::CHAR_CR);
          say("CC:S,17", ascd_pkg::CHAR_LF);
        end
        pressure_done = 1'b1;
      end
    end
    write_best(ascd_pkg::SCORE_MAX);
    say("CC:RB", ascd_pkg::CHAR_LF);

    wait_results_done();
    $display("Run sent %0d characters, checked %0d results and made %0d register writes,",
             chars_sent, checked, cfg_writes);
    $display("covering empty, overlong and malformed lines, saturation and a long stall.");
    if (failures == 0) begin
      $display("ascii_score_command_decoder regression: pass");
    end else begin
      $display("ascii_score_command_decoder regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ascd_pkg.sv
rtl/ascd_line_parser.sv
rtl/ascd_score_exec.sv
rtl/ascii_score_command_decoder.sv
tb/ascii_score_command_decoder_checker.sv
tb/ascii_score_command_decoder_test.sv
